// ----- design/stks_pkg.sv -----
// types and constants for the sorted table key search core
// no dependencies; used by the core and its checker
package stks_pkg;

  localparam int KEY_W       = 64;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam int KL_W        = 4;
  localparam int MAG_W       = 27;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SORTED_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_COUNT  = 2'd2;

  localparam logic [KL_W-1:0] KEY_LENGTH_RST = 4'd8;
  localparam int              RADIX          = 10;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_LOAD  = 2'd0,
    STATUS_FOUND = 2'd1,
    STATUS_MISS  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMP_LT,
    CMP_EQ,
    CMP_GT
  } cmp_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGIT,
    PH_DONE
  } parse_phase_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } parsed_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE_CMP,
    ST_PROBE_UPD,
    ST_SCAN_CMP,
    ST_SCAN_UPD,
    ST_EMIT
  } state_t;

endpackage

// ----- design/sorted_table_key_search_core.sv -----
// sorted table key search: key memory, binary search then linear tail scan
// depends on stks_pkg
// a load goes from ST_IDLE to ST_EMIT; a query runs binary search probes, probes <=
//   log2(sorted)+1, and on no match scans the tail entries before ST_EMIT
// one transaction at a time; each probe or scan step is a memory read on the
//   single read port, then a registered compare state and an update state
// reset: synchronous active low, configuration to defaults, key memory is not cleared
module sorted_table_key_search_core import stks_pkg::*; #(
  parameter int DEPTH     = 256,
  parameter int KEY_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // entry_index, entry_key, target
  input  logic                   in_tuser,   // cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // match_index, from_scan, zero pad
  output logic [1:0]             out_tuser,  // status
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW  = 8 * KEY_BYTES;
  localparam int CAP = (DEPTH < 511) ? DEPTH : 511;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);
  localparam logic [KL_W-1:0]  KB_C  = KL_W'(KEY_BYTES);

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic cmp_t str_cmp(logic [KEY_W-1:0] tgt, logic [KW-1:0] key,
                                   logic [KL_W-1:0] n);
    cmp_t       res;
    logic       done;
    logic [7:0] a;
    logic [7:0] b;
    res  = CMP_EQ;
    done = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      a = tgt[KEY_W-1-8*i -: 8];
      b = key[KW-1-8*i -: 8];
      if (!done && (KL_W'(i) < n)) begin
        if (a != b) begin
          res  = (a < b) ? CMP_LT : CMP_GT;
          done = 1'b1;
        end else if (a == CH_NUL) begin
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic parsed_t parse_key(logic [KW-1:0] key);
    parsed_t      r;
    parse_phase_t phase;
    logic [7:0]   c;
    r.neg = 1'b0;
    r.mag = '0;
    phase = PH_LEAD;
    for (int i = 0; i < KEY_BYTES; i++) begin
      c = key[KW-1-8*i -: 8];
      case (phase)
        PH_LEAD: begin
          if (!is_blank(c)) begin
            if ((c == CH_PLUS) || (c == CH_MINUS)) begin
              r.neg = (c == CH_MINUS);
              phase = PH_DIGIT;
            end else if (is_digit(c)) begin
              r.mag = MAG_W'(c[3:0]);
              phase = PH_DIGIT;
            end else begin
              phase = PH_DONE;
            end
          end
        end
        PH_DIGIT: begin
          if (is_digit(c)) begin
            r.mag = MAG_W'(r.mag * MAG_W'(RADIX) + MAG_W'(c[3:0]));
          end else begin
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // input fields
  cmd_t             in_cmd;
  logic [IDX_W-1:0] in_entry_index;
  logic [KEY_W-1:0] in_entry_key;
  logic [KEY_W-1:0] in_target;

  assign in_cmd         = cmd_t'(in_tuser);
  assign in_entry_index = in_tdata[IDX_W-1:0];
  assign in_entry_key   = in_tdata[IDX_W+KEY_W-1:IDX_W];
  assign in_target      = in_tdata[IDX_W+2*KEY_W-1:IDX_W+KEY_W];

  // configuration
  logic [KL_W-1:0]  key_length_r;
  logic [CNT_W-1:0] sorted_count_r;
  logic [CNT_W-1:0] total_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r   <= KEY_LENGTH_RST;
      sorted_count_r <= '0;
      total_count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LENGTH:   key_length_r   <= cfg_wdata[KL_W-1:0];
        CFG_SORTED_COUNT: sorted_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_TOTAL_COUNT:  total_count_r  <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] s_sat;
  logic [CNT_W-1:0] t_sat;
  logic [KL_W-1:0]  n_eff;

  assign s_sat = (sorted_count_r > CAP_C) ? CAP_C : sorted_count_r;
  assign t_sat = (total_count_r > CAP_C) ? CAP_C : total_count_r;
  assign n_eff = (key_length_r > KB_C) ? KB_C : key_length_r;

  // key memory
  logic [KW-1:0] key_mem [DEPTH];
  logic [KW-1:0] rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[AW'(in_entry_index)] <= in_entry_key[KEY_W-1 -: KW];
    end
    if (rd_en) begin
      rd_data_r <= key_mem[rd_addr];
    end
  end

  // search state
  state_t           state_r,      state_nxt;
  logic [CNT_W-1:0] low_r,        low_nxt;
  logic [CNT_W-1:0] high_r,       high_nxt;
  logic [CNT_W-1:0] probe_r,      probe_nxt;
  logic [KEY_W-1:0] tgt_r,        tgt_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [IDX_W-1:0] res_index_r,  res_index_nxt;
  logic             res_scan_r,   res_scan_nxt;
  logic             out_valid_r,  out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_index_r,  out_index_nxt;
  logic             out_scan_r,   out_scan_nxt;

  // compare stage on read data
  cmp_t    str_res_r;
  parsed_t key_par_r;

  always_ff @(posedge clk) begin
    str_res_r <= str_cmp(tgt_r, rd_data_r, n_eff);
    key_par_r <= parse_key(rd_data_r);
  end

  logic signed [MAG_W:0]   kval;
  logic signed [KEY_W-1:0] kext;
  cmp_t                    cmp_int;
  cmp_t                    cmp_now;
  logic [CNT_W-1:0]        step_up;
  logic [CNT_W-1:0]        step_dn;

  assign kval    = key_par_r.neg ? -$signed({1'b0, key_par_r.mag})
                                 :  $signed({1'b0, key_par_r.mag});
  assign kext    = {{(KEY_W-MAG_W-1){kval[MAG_W]}}, kval};
  assign cmp_int = ($signed(tgt_r) > kext) ? CMP_GT :
                   ($signed(tgt_r) == kext) ? CMP_EQ : CMP_LT;
  assign cmp_now = (key_length_r == '0) ? cmp_int : str_res_r;
  assign step_up = (high_r - probe_r) >> 1;
  assign step_dn = (probe_r - low_r) >> 1;

  always_comb begin
    state_nxt      = state_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    probe_nxt      = probe_r;
    tgt_nxt        = tgt_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_scan_nxt   = res_scan_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_scan_nxt   = out_scan_r;
    rd_en          = 1'b0;
    rd_addr        = AW'(probe_r);
    wr_en          = 1'b0;
    in_tready      = (state_r == ST_IDLE);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          res_index_nxt = '0;
          res_scan_nxt  = 1'b0;
          if (in_cmd == CMD_LOAD) begin
            wr_en          = ({24'd0, in_entry_index} < 32'(DEPTH));
            res_status_nxt = STATUS_LOAD;
            state_nxt      = ST_EMIT;
          end else begin
            tgt_nxt   = in_target;
            low_nxt   = '0;
            high_nxt  = s_sat;
            probe_nxt = s_sat >> 1;
            if (s_sat != '0) begin
              rd_en     = 1'b1;
              rd_addr   = AW'(probe_nxt);
              state_nxt = ST_PROBE_CMP;
            end else if (s_sat < t_sat) begin
              probe_nxt = s_sat;
              rd_en     = 1'b1;
              rd_addr   = AW'(s_sat);
              state_nxt = ST_SCAN_CMP;
            end else begin
              res_status_nxt = STATUS_MISS;
              state_nxt      = ST_EMIT;
            end
          end
        end
      end
      ST_PROBE_CMP: begin
        state_nxt = ST_PROBE_UPD;
      end
      ST_PROBE_UPD: begin
        if (cmp_now == CMP_EQ) begin
          res_status_nxt = STATUS_FOUND;
          res_index_nxt  = probe_r[IDX_W-1:0];
          res_scan_nxt   = 1'b0;
          state_nxt      = ST_EMIT;
        end else begin
          if (cmp_now == CMP_GT) begin
            low_nxt   = probe_r + 1'b1;
            probe_nxt = probe_r + step_up;
          end else begin
            high_nxt  = probe_r;
            probe_nxt = probe_r - step_dn - 1'b1;
          end
          if (high_nxt > low_nxt) begin
            rd_en     = 1'b1;
            rd_addr   = AW'(probe_nxt);
            state_nxt = ST_PROBE_CMP;
          end else if (s_sat < t_sat) begin
            probe_nxt = s_sat;
            rd_en     = 1'b1;
            rd_addr   = AW'(s_sat);
            state_nxt = ST_SCAN_CMP;
          end else begin
            res_status_nxt = STATUS_MISS;
            res_index_nxt  = '0;
            res_scan_nxt   = 1'b0;
            state_nxt      = ST_EMIT;
          end
        end
      end
      ST_SCAN_CMP: begin
        state_nxt = ST_SCAN_UPD;
      end
      ST_SCAN_UPD: begin
        if (cmp_now == CMP_EQ) begin
          res_status_nxt = STATUS_FOUND;
          res_index_nxt  = probe_r[IDX_W-1:0];
          res_scan_nxt   = 1'b1;
          state_nxt      = ST_EMIT;
        end else begin
          probe_nxt = probe_r + 1'b1;
          if (probe_nxt < t_sat) begin
            rd_en     = 1'b1;
            rd_addr   = AW'(probe_nxt);
            state_nxt = ST_SCAN_CMP;
          end else begin
            res_status_nxt = STATUS_MISS;
            res_index_nxt  = '0;
            res_scan_nxt   = 1'b0;
            state_nxt      = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_index_r;
          out_scan_nxt   = res_scan_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r        <= low_nxt;
    high_r       <= high_nxt;
    probe_r      <= probe_nxt;
    tgt_r        <= tgt_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_scan_r   <= res_scan_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_scan_r   <= out_scan_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_scan_r, out_index_r};

endmodule

// ----- design/stks_checker.sv -----
// port level checks for the sorted table key search core
// depends on stks_pkg; bound to sorted_table_key_search_core
module stks_checker import stks_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,  // match_index, from_scan, zero pad
  input logic [1:0]             out_tuser   // status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while one is in progress");

  a_miss_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STATUS_MISS) |-> out_tdata == '0)
    else $error("miss carries nonzero index or scan flag");

  a_load_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STATUS_LOAD) |-> out_tdata == '0)
    else $error("load result carries nonzero payload");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind sorted_table_key_search_core stks_checker u_stks_checker (.*);

// ----- dv/tb_sorted_table_key_search_core.sv -----
// testbench for sorted_table_key_search_core: directed rows, then random load and query phases
// results are checked against an in-bench search of a shadow key table or a directed result
// depends on stks_pkg and the core only
`timescale 1ns / 100ps

module tb_sorted_table_key_search_core;
  import stks_pkg::*;

  localparam int ITEM_TARGET    = 1700;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int TABLE_DEPTH    = 256;
  localparam int PRINT_LIMIT    = 50;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] index;
    logic             scan;
  } lookup_res_t;

  localparam lookup_res_t LOAD_DONE = '{status: STATUS_LOAD, index: '0, scan: 1'b0};
  localparam lookup_res_t NO_MATCH  = '{status: STATUS_MISS, index: '0, scan: 1'b0};

  typedef struct {
    bit          is_cfg;
    bit [3:0]    kl;
    bit [8:0]    sc;
    bit [8:0]    tc;
    cmd_t        cmd;
    bit [7:0]    idx;
    bit [63:0]   key;
    bit [63:0]   tgt;
    bit          typed;
    lookup_res_t res;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // shadow of the block state
  bit [63:0]   key_mem [TABLE_DEPTH];
  bit [3:0]    kl_cfg = KEY_LENGTH_RST;
  bit [8:0]    sorted_cfg = '0;
  bit [8:0]    total_cfg = '0;

  bit [63:0]   key_buf [TABLE_DEPTH];
  lookup_res_t pending_results [$];
  lookup_res_t sink_want;
  dir_row_t    directed [$];
  int          items_sent = 0;
  int          results_seen = 0;
  int          err_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 8;
  int          recv_idle_pct = 63;
  int          phase_no = 0;

  sorted_table_key_search_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic bit [7:0] byte_of(bit [63:0] w, int unsigned p);
    if (p >= 8) return CH_NUL;
    return w[63 - 8 * p -: 8];
  endfunction

  // strtoll-like decimal parse confined to the key bytes
  function automatic longint parse_decimal(bit [63:0] key);
    int unsigned p;
    bit [7:0]    c;
    bit          neg;
    longint      mag;
    p = 0;
    neg = 1'b0;
    mag = 0;
    while (p < 8 && (byte_of(key, p) == CH_SPACE ||
                     (byte_of(key, p) >= CH_TAB && byte_of(key, p) <= CH_CR)))
      p++;
    c = byte_of(key, p);
    if (p < 8 && (c == CH_PLUS || c == CH_MINUS)) begin
      neg = (c == CH_MINUS);
      p++;
    end
    while (p < 8) begin
      c = byte_of(key, p);
      if (c < CH_ZERO || c > CH_NINE) break;
      mag = mag * RADIX + longint'(c - CH_ZERO);
      p++;
    end
    return neg ? -mag : mag;
  endfunction

  function automatic int compare_key(bit [63:0] tgt, bit [63:0] key, bit [3:0] kl);
    int unsigned n;
    bit [7:0]    a;
    bit [7:0]    b;
    longint      tv;
    longint      kv;
    if (kl != 0) begin
      n = (kl > 8) ? 8 : kl;
      for (int unsigned i = 0; i < n; i++) begin
        a = byte_of(tgt, i);
        b = byte_of(key, i);
        if (a != b) return (a < b) ? -1 : 1;
        if (a == CH_NUL) return 0;
      end
      return 0;
    end
    tv = longint'(tgt);
    kv = parse_decimal(key);
    if (tv > kv) return 1;
    if (tv < kv) return -1;
    return 0;
  endfunction

  // binary search of the sorted head with the block's probe rule, then tail scan
  function automatic lookup_res_t search_table(bit [63:0] tgt);
    int unsigned s, t, lo, hi, probe;
    int          c;
    lookup_res_t r;
    r = NO_MATCH;
    s = (sorted_cfg > TABLE_DEPTH) ? TABLE_DEPTH : sorted_cfg;
    t = (total_cfg > TABLE_DEPTH) ? TABLE_DEPTH : total_cfg;
    lo = 0;
    hi = s;
    probe = s / 2;
    for (int unsigned iter = 0; iter <= s && hi > lo; iter++) begin
      c = compare_key(tgt, key_mem[probe], kl_cfg);
      if (c > 0) begin
        lo = probe;
        probe += (hi - lo) / 2;
        lo++;
      end else if (c < 0) begin
        hi = probe;
        probe -= (hi - lo) / 2 + 1;
      end else begin
        r.status = STATUS_FOUND;
        r.index = probe[7:0];
        return r;
      end
    end
    for (int unsigned i = s; i < t; i++) begin
      if (compare_key(tgt, key_mem[i], kl_cfg) == 0) begin
        r.status = STATUS_FOUND;
        r.index = i[7:0];
        r.scan = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (err_count < PRINT_LIMIT)
      $display("[%0t] result %0d %s: got %0h want %0h", $time, results_seen, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", {out_tuser, out_tdata}, '0);
        end else begin
          sink_want = pending_results.pop_front();
          if (out_tuser !== sink_want.status)
            report_mismatch("status", out_tuser, sink_want.status);
          if (out_tdata[IDX_W-1:0] !== sink_want.index)
            report_mismatch("match_index", out_tdata[IDX_W-1:0], sink_want.index);
          if (out_tdata[IDX_W] !== sink_want.scan)
            report_mismatch("from_scan", out_tdata[IDX_W], sink_want.scan);
        end
        results_seen++;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sorted_table_key_search_core regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_item(cmd_t cmd, bit [7:0] idx, bit [63:0] key, bit [63:0] tgt,
                           bit typed, lookup_res_t typed_res);
    lookup_res_t pred;
    if (items_sent < ITEM_TARGET / 3) begin
      send_idle_pct = 8;
      recv_idle_pct = 63;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 63;
      recv_idle_pct = 8;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {tgt, key, idx};
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_LOAD) begin
      key_mem[idx] = key;
      pred = LOAD_DONE;
    end else begin
      pred = search_table(tgt);
    end
    pending_results.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  task automatic issue_load(bit [7:0] idx, bit [63:0] key);
    send_item(CMD_LOAD, idx, key, {$urandom, $urandom}, 1'b0, LOAD_DONE);
  endtask

  task automatic issue_query(bit [63:0] tgt);
    send_item(CMD_QUERY, 8'($urandom), {$urandom, $urandom}, tgt, 1'b0, LOAD_DONE);
  endtask

  // hold off until every transaction has its result, then sync to a rising clock edge
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic apply_config(bit [3:0] kl, bit [8:0] sc, bit [8:0] tc, bit poke);
    cfg_we <= 1'b1;
    cfg_index <= CFG_KEY_LENGTH;
    cfg_wdata <= {5'($urandom), kl};
    @(posedge clk);
    kl_cfg = kl;
    cfg_index <= CFG_SORTED_COUNT;
    cfg_wdata <= sc;
    @(posedge clk);
    sorted_cfg = sc;
    cfg_index <= CFG_TOTAL_COUNT;
    cfg_wdata <= tc;
    @(posedge clk);
    total_cfg = tc;
    if (poke) begin
      cfg_index <= CFG_UNUSED;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic bit [63:0] make_string_key();
    bit [63:0]   w;
    int unsigned r;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) w = {w[55:0], CH_NUL};
      else if (r == 1) w = {w[55:0], 8'hFF};
      else if (r < 6) w = {w[55:0], 8'h61 + 8'($urandom_range(0, 3))};
      else w = {w[55:0], 8'($urandom)};
    end
    return w;
  endfunction

  function automatic bit [63:0] make_decimal_key();
    bit [7:0]    b [8];
    bit [63:0]   w;
    int unsigned p, n;
    for (int i = 0; i < 8; i++)
      b[i] = $urandom_range(0, 1) ? CH_NUL : 8'($urandom);
    p = 0;
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      b[p] = $urandom_range(0, 1) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
      p++;
    end
    case ($urandom_range(0, 3))
      0: begin b[p] = CH_PLUS; p++; end
      1: begin b[p] = CH_MINUS; p++; end
      default: ;
    endcase
    n = $urandom_range(0, 8 - p);
    for (int i = 0; i < n; i++) begin
      b[p] = CH_ZERO + 8'($urandom_range(0, 9));
      p++;
    end
    w = '0;
    for (int i = 0; i < 8; i++) w = {w[55:0], b[i]};
    return w;
  endfunction

  function automatic bit [63:0] pick_target(bit [3:0] kl, int unsigned need);
    int unsigned r, n;
    bit [63:0]   k, mask;
    longint      v;
    r = $urandom_range(0, 9);
    if (need > 0 && r < 6) begin
      k = key_mem[$urandom_range(0, need - 1)];
      if (kl == 0) begin
        v = parse_decimal(k);
        if (r == 5) v = $urandom_range(0, 1) ? v + 1 : v - 1;
        return 64'(v);
      end
      n = (kl > 8) ? 8 : kl;
      mask = (n == 8) ? '0 : ({64{1'b1}} >> (8 * n));
      k = (k & ~mask) | ({$urandom, $urandom} & mask);
      if (r == 5) k[$urandom_range(64 - 8 * n, 63)] ^= 1'b1;
      return k;
    end
    case (r)
      6: case ($urandom_range(0, 3))
           0: return '0;
           1: return {64{1'b1}};
           2: return 64'h8000_0000_0000_0000;
           default: return 64'h7FFF_FFFF_FFFF_FFFF;
         endcase
      7: return 64'(longint'($urandom_range(0, 200)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // configure, load a sorted head and a random tail, then query it with random loads mixed in
  task automatic run_phase(bit full);
    int unsigned s_eff, t_eff, need, nq, r;
    int          j;
    bit [3:0]    kl;
    bit [8:0]    sc, tc;
    bit [7:0]    order [TABLE_DEPTH];
    bit [7:0]    tmp8;
    bit [63:0]   tmpk;
    bit [63:0]   prev;
    wait_idle();
    r = $urandom_range(0, 9);
    kl = (r < 3) ? 4'd0 : (r < 9) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(9, 15));
    if (full) begin
      sc = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 255)) : 9'($urandom_range(256, 511));
      tc = 9'($urandom_range(0, 511));
      s_eff = (sc > TABLE_DEPTH) ? TABLE_DEPTH : sc;
      t_eff = (tc > TABLE_DEPTH) ? TABLE_DEPTH : tc;
      nq = 40;
    end else begin
      s_eff = $urandom_range(0, 24);
      t_eff = s_eff + $urandom_range(0, 8);
      if ($urandom_range(0, 5) == 0) t_eff = $urandom_range(0, s_eff);
      sc = 9'(s_eff);
      tc = 9'(t_eff);
      nq = $urandom_range(4, 16);
    end
    need = (s_eff > t_eff) ? s_eff : t_eff;
    apply_config(kl, sc, tc, $urandom_range(0, 3) == 0);
    for (int i = 0; i < need; i++)
      key_buf[i] = (kl == 0) ? make_decimal_key() : make_string_key();
    for (int i = 1; i < s_eff; i++) begin
      tmpk = key_buf[i];
      j = i;
      while (j > 0) begin
        // integer keys order by their parsed value
        prev = (kl == 0) ? 64'(parse_decimal(key_buf[j - 1])) : key_buf[j - 1];
        if (compare_key(prev, tmpk, kl) <= 0) break;
        key_buf[j] = key_buf[j - 1];
        j--;
      end
      key_buf[j] = tmpk;
    end
    for (int i = 0; i < need; i++) order[i] = 8'(i);
    for (int i = need; i > 1; i--) begin
      j = $urandom_range(0, i - 1);
      tmp8 = order[i - 1];
      order[i - 1] = order[j];
      order[j] = tmp8;
    end
    for (int i = 0; i < need; i++) issue_load(order[i], key_buf[order[i]]);
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(0, 7) == 0) issue_load(8'($urandom), {$urandom, $urandom});
      else issue_query(pick_target(kl, need));
    end
  endtask

  function automatic dir_row_t cfg_row(bit [3:0] kl, bit [8:0] sc, bit [8:0] tc);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.kl = kl;
    r.sc = sc;
    r.tc = tc;
    r.cmd = CMD_LOAD;
    r.idx = '0;
    r.key = '0;
    r.tgt = '0;
    r.typed = 1'b0;
    r.res = LOAD_DONE;
    return r;
  endfunction

  function automatic dir_row_t load_row(bit [7:0] idx, bit [63:0] key);
    dir_row_t r;
    r = cfg_row('0, '0, '0);
    r.is_cfg = 1'b0;
    r.idx = idx;
    r.key = key;
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t query_row(bit [63:0] tgt, bit typed, lookup_res_t res);
    dir_row_t r;
    r = cfg_row('0, '0, '0);
    r.is_cfg = 1'b0;
    r.cmd = CMD_QUERY;
    r.tgt = tgt;
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    directed = '{
      query_row(64'h0, 1'b1, NO_MATCH),
      load_row(8'd0, 64'h0000_0000_0000_0000),
      load_row(8'd1, 64'h4142_4300_0000_0000),
      load_row(8'd2, 64'h4142_4344_4546_4748),
      load_row(8'd3, 64'hFFFF_FFFF_FFFF_FFFF),
      load_row(8'd4, 64'h7A7A_7A7A_7A7A_7A7A),
      load_row(8'd5, 64'h1234_5678_9ABC_DEF0),
      cfg_row(4'd8, 9'd4, 9'd6),
      query_row(64'h0, 1'b0, NO_MATCH),
      query_row(64'h4142_4300_DEAD_BEEF, 1'b0, NO_MATCH),
      query_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_MATCH),
      query_row(64'h1234_5678_9ABC_DEF0, 1'b0, NO_MATCH),
      query_row(64'h4142_4344_4546_4749, 1'b0, NO_MATCH),
      cfg_row(4'd3, 9'd4, 9'd6),
      query_row(64'h4142_4399_9999_9999, 1'b0, NO_MATCH),
      cfg_row(4'd15, 9'd0, 9'd6),
      query_row(64'h7A7A_7A7A_7A7A_7A7A, 1'b0, NO_MATCH),
      cfg_row(4'd0, 9'd4, 9'd2),
      load_row(8'd0, 64'h2D31_3233_3435_3637),
      load_row(8'd1, 64'h6162_6300_0000_0000),
      load_row(8'd2, 64'h2009_2B34_3278_797A),
      load_row(8'd3, 64'h3939_3939_3939_3939),
      query_row(64'hFFFF_FFFF_FFED_2979, 1'b0, NO_MATCH),
      query_row(64'h0000_0000_0000_002A, 1'b0, NO_MATCH),
      query_row(64'h0000_0001_0000_002A, 1'b0, NO_MATCH),
      query_row(64'h0000_0000_05F5_E0FF, 1'b0, NO_MATCH),
      query_row(64'h8000_0000_0000_0000, 1'b1, NO_MATCH),
      query_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, NO_MATCH)
    };
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_idle();
        apply_config(directed[i].kl, directed[i].sc, directed[i].tc, 1'b0);
      end else begin
        send_item(directed[i].cmd, directed[i].idx, directed[i].key, directed[i].tgt,
                  directed[i].typed, directed[i].typed ? directed[i].res : LOAD_DONE);
      end
    end
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase_no == 1 || $urandom_range(0, 11) == 0);
      phase_no++;
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("sorted_table_key_search_core regression: pass");
    end else begin
      $display("sorted_table_key_search_core regression: fail");
    end
    $finish;
  end

endmodule
